// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the fire effect RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fec_pkg.sv =====
// Shared constants, cell command codes and the cell control struct
// for the fire effect engine. Depends on nothing.
`timescale 1ns / 1ps

package fec_pkg;

  localparam int PIXELS = 32;

  localparam int IDX_W  = 6;
  localparam int HEAT_W = 8;
  localparam int RAND_W = 32;
  localparam int COOL_W = 10;
  localparam int THR_W  = 8;

  // Item opcodes.
  localparam logic OP_COOL  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // Register indexes, one per 32-bit word of the register port.
  localparam int REG_W = 1;
  localparam logic [REG_W-1:0] REG_COOLING_RATE    = 1'b0;
  localparam logic [REG_W-1:0] REG_SPARK_THRESHOLD = 1'b1;

  // Largest cooling divisor sets the remainder width.
  localparam int DIV_MAX = ((1 << COOL_W) - 1) * 10 / PIXELS + 2;
  localparam int REM_W   = $clog2(DIV_MAX + 1);
  localparam int AMT_W   = REM_W;

  // Divider: quotient bits resolved per cycle and iterations per item.
  localparam int DIV_STEPS  = 4;
  localparam int DIV_ITERS  = RAND_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_ITERS);

  localparam int SPARK_MOD  = 95;
  localparam int SPARK_BASE = 160;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_HOLD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_COOL    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DIFFUSE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SPARK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROTATE  = 3'd4;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] sel;
    logic [AMT_W-1:0] amount;
  } fec_ctl_t;

endpackage

// ===== rtl/fec_cell.sv =====
// One heat cell of the fire chain: holds one heat value, updates it on
// a broadcast command from neighbors or an amount. Depends on fec_pkg.
`timescale 1ns / 1ps

module fec_cell import fec_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  cell_idx,
  input  fec_ctl_t          ctl,
  input  logic [HEAT_W-1:0] left1,
  input  logic [HEAT_W-1:0] left2,
  input  logic [HEAT_W-1:0] right,
  output logic [HEAT_W-1:0] heat
);

  logic [HEAT_W-1:0] heat_r;
  logic [HEAT_W-1:0] heat_nxt;
  logic [9:0]        mix_sum;
  logic [19:0]       mix_prod;
  logic [HEAT_W-1:0] mix_third;
  logic              hit;

  assign hit       = (ctl.sel == cell_idx);
  assign mix_sum   = 10'(left1) + {1'b0, left2, 1'b0};
  // Divide by three: multiply by 683 / 2048, exact for sums up to 765.
  assign mix_prod  = 20'(mix_sum) * 20'd683;
  assign mix_third = mix_prod[18:11];

  always_comb begin
    heat_nxt = heat_r;
    case (ctl.cmd)
      CMD_COOL: begin
        if (hit) begin
          if (AMT_W'(heat_r) > ctl.amount) begin
            heat_nxt = heat_r - ctl.amount[HEAT_W-1:0];
          end else begin
            heat_nxt = '0;
          end
        end
      end
      CMD_DIFFUSE: begin
        if (cell_idx >= IDX_W'(2)) begin
          heat_nxt = mix_third;
        end
      end
      CMD_SPARK: begin
        if (hit) begin
          heat_nxt = heat_r + ctl.amount[HEAT_W-1:0];
        end
      end
      CMD_ROTATE: heat_nxt = right;
      default:    heat_nxt = heat_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_r <= '0;
    end else begin
      heat_r <= heat_nxt;
    end
  end

  assign heat = heat_r;

endmodule

// ===== rtl/fec_divider.sv =====
// Iterative remainder unit: 32-bit dividend over a narrow divisor,
// four quotient bits per cycle. Depends on fec_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fec_divider import fec_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [REM_W-1:0]  divisor,
  output logic              done,
  output logic [REM_W-1:0]  remainder
);

  logic                 busy_r,  busy_nxt;
  logic                 done_r,  done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [RAND_W-1:0]    dvd_r,   dvd_nxt;
  logic [REM_W-1:0]     dsr_r,   dsr_nxt;
  logic [REM_W-1:0]     rem_r,   rem_nxt;
  logic [RAND_W-1:0]    dvd_v;
  logic [REM_W-1:0]     rem_v;
  logic [REM_W:0]       part;
  logic                 last_iter;

  assign last_iter = (cnt_r == DIV_CNT_W'(DIV_ITERS - 1));

  // Restoring steps: shift in one dividend bit, subtract when it fits.
  always_comb begin
    rem_v = rem_r;
    dvd_v = dvd_r;
    part  = '0;
    for (int j = 0; j < DIV_STEPS; j++) begin
      part  = {rem_v, dvd_v[RAND_W-1]};
      dvd_v = {dvd_v[RAND_W-2:0], 1'b0};
      if (part >= {1'b0, dsr_r}) begin
        rem_v = REM_W'(part - {1'b0, dsr_r});
      end else begin
        rem_v = part[REM_W-1:0];
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = dvd_v;
      rem_nxt = rem_v;
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (last_iter) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

  `ASSERT_IMPLIES(a_no_restart, clk, rst_n, start, !busy_r, "divider started while busy")

endmodule

// ===== rtl/led_fire_effect_engine.sv =====
// Top level of the fire effect engine: sequencer, cell chain, divider,
// colour map and register port. Depends on fec_pkg, fec_cell, fec_divider.
//
// Usage: items enter on the in_ channel (valid/ready). A cool item
// (opcode 0) lowers one cell's heat by a random amount; in_ready rises
// again once the shared remainder unit, which resolves four bits of the
// 32-bit random word per cycle, has produced that amount.
// A frame item (opcode 1) diffuses heat one cell upward, optionally adds a
// spark near the bottom, then streams one colour item per pixel on the out_
// channel, pixel 0 first, last_pixel set on the final one. The first pixel
// appears once the divider has produced the spark heat; the rest follow one
// per cycle while the receiver does not stall. Pixels leave by rotating the
// cell chain past cell 0, one step per delivered pixel.
// A stalled receiver holds the output register and freezes the chain; no
// pixel is lost. in_ready is high only while the sequencer is idle.
// Reset (rst_n low, synchronous) zeroes every heat cell and loads the
// registers: cooling_rate 55 at byte 0, spark_threshold 120 at byte 4.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_fire_effect_engine import fec_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [IDX_W-1:0]  in_cell_index,
  input  logic [RAND_W-1:0] in_rand_first,
  input  logic [RAND_W-1:0] in_rand_second,
  input  logic [RAND_W-1:0] in_rand_third,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_pixel_index,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic              out_last_pixel,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CNT_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIFF = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  localparam logic [7:0] T_WHITE  = 8'h80;
  localparam logic [7:0] T_YELLOW = 8'h40;

  // Reduce mod 255: 256 is one mod 255, so fold bytes.
  function automatic logic [7:0] mod255(input logic [RAND_W-1:0] v);
    logic [9:0] s;
    logic [8:0] f;
    begin
      s = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[23:16]) + 10'(v[31:24]);
      f = 9'(s[7:0]) + 9'(s[9:8]);
      if (f >= 9'd255) begin
        f = f - 9'd255;
      end
      mod255 = f[7:0];
    end
  endfunction

  // Reduce mod 7: 8 is one mod 7, so fold 3-bit groups.
  function automatic logic [2:0] mod7(input logic [RAND_W-1:0] v);
    logic [RAND_W:0] p;
    logic [6:0]      s;
    logic [3:0]      s2;
    logic [3:0]      s3;
    begin
      p = {1'b0, v};
      s = '0;
      for (int i = 0; i < 11; i++) begin
        s = s + 7'(p[3*i +: 3]);
      end
      s2 = 4'(s[2:0]) + 4'(s[5:3]) + 4'(s[6]);
      s3 = 4'(s2[2:0]) + 4'(s2[3]);
      if (s3 >= 4'd7) begin
        s3 = s3 - 4'd7;
      end
      mod7 = s3[2:0];
    end
  endfunction

  // Heat to colour: t = heat * 191 / 255, division by reciprocal plus fixup.
  function automatic logic [23:0] heat_to_rgb(input logic [HEAT_W-1:0] h);
    logic [15:0] x;
    logic [24:0] xm;
    logic [7:0]  q;
    logic [16:0] r;
    logic [7:0]  t;
    logic [7:0]  ramp;
    begin
      x  = 16'(h) * 16'd191;
      xm = 25'(x) * 25'd257;
      q  = xm[23:16];
      r  = 17'(x) - 17'(q) * 17'd255;
      t  = (r >= 17'd255) ? q + 8'd1 : q;
      ramp = {t[5:0], 2'b00};
      if (t > T_WHITE) begin
        heat_to_rgb = {8'd255, 8'd255, ramp};
      end else if (t > T_YELLOW) begin
        heat_to_rgb = {8'd255, ramp, 8'd0};
      end else begin
        heat_to_rgb = {ramp, 8'd0, 8'd0};
      end
    end
  endfunction

  logic [1:0]        state_r,      state_nxt;
  logic              op_r,         op_nxt;
  logic [IDX_W-1:0]  cell_r,       cell_nxt;
  logic              spark_r,      spark_nxt;
  logic [IDX_W-1:0]  spark_cell_r, spark_cell_nxt;
  logic [CNT_W-1:0]  pix_cnt_r,    pix_cnt_nxt;
  logic              out_valid_r,  out_valid_nxt;
  logic [IDX_W-1:0]  out_pixel_index_r;
  logic [7:0]        out_red_r, out_green_r, out_blue_r;
  logic              out_last_pixel_r;
  logic [COOL_W-1:0] cooling_r;
  logic [THR_W-1:0]  spark_thr_r;

  logic              accept;
  logic              load;
  logic              cfg_write;
  logic [13:0]       cool_scaled;
  logic [REM_W-1:0]  cool_div;
  logic [RAND_W-1:0] div_dividend;
  logic [REM_W-1:0]  div_divisor;
  logic              div_done;
  logic [REM_W-1:0]  div_rem;
  logic [23:0]       rgb;
  fec_ctl_t          ctl;
  logic [HEAT_W-1:0] heat [PIXELS];

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign load      = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign cfg_write = psel && penable && pwrite && pready;

  // Cooling divisor: cooling_rate * 10 / PIXELS + 2.
  assign cool_scaled  = 14'(cooling_r) * 14'd10;
  assign cool_div     = REM_W'(cool_scaled / PIXELS) + REM_W'(2);
  assign div_dividend = (in_opcode == OP_FRAME) ? in_rand_third : in_rand_first;
  assign div_divisor  = (in_opcode == OP_FRAME) ? REM_W'(SPARK_MOD) : cool_div;

  fec_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Cell chain: each cell sees its two lower neighbors and its upper one.
  for (genvar i = 0; i < PIXELS; i++) begin : g_cell
    fec_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(i)),
      .ctl      (ctl),
      .left1    (heat[(i + PIXELS - 1) % PIXELS]),
      .left2    (heat[(i + PIXELS - 2) % PIXELS]),
      .right    (heat[(i + 1) % PIXELS]),
      .heat     (heat[i])
    );
  end

  assign rgb = heat_to_rgb(heat[0]);

  // Sequencer and chain commands.
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cell_nxt       = cell_r;
    spark_nxt      = spark_r;
    spark_cell_nxt = spark_cell_r;
    pix_cnt_nxt    = pix_cnt_r;
    ctl.cmd        = CMD_HOLD;
    ctl.sel        = '0;
    ctl.amount     = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt         = in_opcode;
          cell_nxt       = in_cell_index;
          spark_nxt      = (mod255(in_rand_first) < spark_thr_r);
          spark_cell_nxt = IDX_W'(mod7(in_rand_second));
          pix_cnt_nxt    = '0;
          state_nxt      = (in_opcode == OP_FRAME) ? ST_DIFF : ST_DIV;
        end
      end
      ST_DIFF: begin
        // diffuse while the divider works on the spark heat
        ctl.cmd   = CMD_DIFFUSE;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (op_r == OP_COOL) begin
            ctl.cmd    = CMD_COOL;
            ctl.sel    = cell_r;
            ctl.amount = div_rem;
            state_nxt  = ST_IDLE;
          end else begin
            if (spark_r) begin
              ctl.cmd    = CMD_SPARK;
              ctl.sel    = spark_cell_r;
              ctl.amount = div_rem + AMT_W'(SPARK_BASE);
            end
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load) begin
          // advance the chain so the next pixel sits in cell 0
          ctl.cmd     = CMD_ROTATE;
          pix_cnt_nxt = pix_cnt_r + CNT_W'(1);
          if (pix_cnt_r == CNT_W'(PIXELS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output register: load on a free slot, drop on acceptance.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pix_cnt_r   <= '0;
      cooling_r   <= COOL_W'(55);
      spark_thr_r <= THR_W'(120);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pix_cnt_r   <= pix_cnt_nxt;
      if (cfg_write && (paddr[2] == REG_COOLING_RATE)) begin
        cooling_r <= pwdata[COOL_W-1:0];
      end
      if (cfg_write && (paddr[2] == REG_SPARK_THRESHOLD)) begin
        spark_thr_r <= pwdata[THR_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    cell_r       <= cell_nxt;
    spark_r      <= spark_nxt;
    spark_cell_r <= spark_cell_nxt;
    if (load) begin
      out_pixel_index_r <= IDX_W'(pix_cnt_r);
      out_red_r         <= rgb[23:16];
      out_green_r       <= rgb[15:8];
      out_blue_r        <= rgb[7:0];
      out_last_pixel_r  <= (pix_cnt_r == CNT_W'(PIXELS - 1));
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_pixel_index_r;
  assign out_red         = out_red_r;
  assign out_green       = out_green_r;
  assign out_blue        = out_blue_r;
  assign out_last_pixel  = out_last_pixel_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SPARK_THRESHOLD) ? 32'(spark_thr_r) : 32'(cooling_r);

  `ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_r != ST_IDLE, "accepted item left sequencer idle")
  `ASSERT_IMPLIES(a_done_in_div, clk, rst_n, div_done, state_r == ST_DIV, "divider finished outside wait state")
  `ASSERT_NEXT(a_last_ends_frame, clk, rst_n, load && (pix_cnt_r == CNT_W'(PIXELS - 1)), (state_r == ST_IDLE) && out_valid_r && out_last_pixel_r, "final pixel did not close the frame")

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for led_fire_effect_engine: random and directed
// cool/frame items, per-pixel colour checking against an internal heat model.
// Depends on fec_pkg and the engine RTL only.
`timescale 1ns / 1ps

module testbench;
  import fec_pkg::*;

  localparam int RESET_CYCLES   = 7;
  // A cool item keeps the engine busy with nothing to show.
  localparam int DRAIN_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PRESSURE_HOLD  = 300;

  typedef struct {
    logic              opcode;
    logic [IDX_W-1:0]  cell_index;
    logic [RAND_W-1:0] rand_first;
    logic [RAND_W-1:0] rand_second;
    logic [RAND_W-1:0] rand_third;
  } fire_item_t;

  typedef struct {
    logic [IDX_W-1:0] pixel_index;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             last_pixel;
  } pixel_colour_t;

  // Every input starts at a known value.
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic              in_opcode      = 1'b0;
  logic [IDX_W-1:0]  in_cell_index  = '0;
  logic [RAND_W-1:0] in_rand_first  = '0;
  logic [RAND_W-1:0] in_rand_second = '0;
  logic [RAND_W-1:0] in_rand_third  = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [IDX_W-1:0]  out_pixel_index;
  logic [7:0]        out_red;
  logic [7:0]        out_green;
  logic [7:0]        out_blue;
  logic              out_last_pixel;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [2:0]        paddr          = '0;
  logic [31:0]       pwdata         = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Shadow copy of the engine state and registers.
  logic [HEAT_W-1:0] heat_shadow [PIXELS];
  logic [COOL_W-1:0] cooling_rate_shadow    = 10'd55;
  logic [THR_W-1:0]  spark_threshold_shadow = 8'd120;

  fire_item_t    pending_items[$];
  pixel_colour_t expected_pixels[$];
  fire_item_t    next_item;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  bit in_taken       = 1'b0;
  int idle_cycles    = 0;

  int error_count    = 0;
  int items_accepted = 0;
  int frames_seen    = 0;
  int sparks_seen    = 0;
  int cools_ignored  = 0;
  int pixels_checked = 0;
  int settings_run   = 1;

  led_fire_effect_engine u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_cell_index   (in_cell_index),
    .in_rand_first   (in_rand_first),
    .in_rand_second  (in_rand_second),
    .in_rand_third   (in_rand_third),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  // Advance the heat model by one accepted item and queue the pixels it emits.
  task automatic step_fire_model(input fire_item_t it);
    int unsigned rate, divisor, cooldown, heat, y, t, ramp;
    pixel_colour_t px;
    if (it.opcode == OP_COOL) begin
      if (it.cell_index < PIXELS) begin
        rate     = cooling_rate_shadow;
        divisor  = rate * 10 / PIXELS + 2;
        cooldown = it.rand_first % divisor;
        heat     = heat_shadow[it.cell_index];
        heat_shadow[it.cell_index] = HEAT_W'((heat > cooldown) ? heat - cooldown : 0);
      end else begin
        cools_ignored++;
      end
    end else begin
      frames_seen++;
      // Diffuse upward, top cell first so each reads the old values below.
      for (int k = PIXELS - 1; k >= 2; k--) begin
        heat_shadow[k] = HEAT_W'((32'(heat_shadow[k-1]) + 2 * 32'(heat_shadow[k-2])) / 3);
      end
      if ((it.rand_first % 255) < spark_threshold_shadow) begin
        sparks_seen++;
        y = it.rand_second % 7;
        // Wrap mod 256 on overflow, as the original effect does.
        heat_shadow[y] = 8'(32'(heat_shadow[y]) + (it.rand_third % 95) + 160);
      end
      for (int k = 0; k < PIXELS; k++) begin
        t    = 32'(heat_shadow[k]) * 191 / 255;
        ramp = (t & 32'h3F) << 2;
        px.pixel_index = k[IDX_W-1:0];
        px.last_pixel  = (k == PIXELS - 1);
        if (t > 32'h80) begin
          px.red = 8'd255; px.green = 8'd255; px.blue = ramp[7:0];
        end else if (t > 32'h40) begin
          px.red = 8'd255; px.green = ramp[7:0]; px.blue = 8'd0;
        end else begin
          px.red = ramp[7:0]; px.green = 8'd0; px.blue = 8'd0;
        end
        expected_pixels.push_back(px);
      end
    end
  endtask

  // Driver: present the next pending item once the current one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = pending_items.pop_front();
        in_valid       <= 1'b1;
        in_opcode      <= next_item.opcode;
        in_cell_index  <= next_item.cell_index;
        in_rand_first  <= next_item.rand_first;
        in_rand_second <= next_item.rand_second;
        in_rand_third  <= next_item.rand_third;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left  = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check delivered pixels, then predict from accepted items.
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel %0d delivered", out_pixel_index);
        error_count++;
      end else begin
        pixel_colour_t exp_px;
        exp_px = expected_pixels.pop_front();
        pixels_checked++;
        if (out_pixel_index !== exp_px.pixel_index) begin
          $error("pixel_index expected %0d actual %0d", exp_px.pixel_index,
                 out_pixel_index);
          error_count++;
        end
        if (out_red !== exp_px.red) begin
          $error("red expected %0d actual %0d", exp_px.red, out_red);
          error_count++;
        end
        if (out_green !== exp_px.green) begin
          $error("green expected %0d actual %0d", exp_px.green, out_green);
          error_count++;
        end
        if (out_blue !== exp_px.blue) begin
          $error("blue expected %0d actual %0d", exp_px.blue, out_blue);
          error_count++;
        end
        if (out_last_pixel !== exp_px.last_pixel) begin
          $error("last_pixel expected %0d actual %0d", exp_px.last_pixel,
                 out_last_pixel);
          error_count++;
        end
      end
    end
    if (in_taken) begin
      fire_item_t seen;
      seen.opcode      = in_opcode;
      seen.cell_index  = in_cell_index;
      seen.rand_first  = in_rand_first;
      seen.rand_second = in_rand_second;
      seen.rand_third  = in_rand_third;
      items_accepted++;
      step_fire_model(seen);
    end
  end

  // Watchdog: any handshake on any port counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic queue_item(input logic op, input int cell_no, input logic [31:0] r1,
                            input logic [31:0] r2, input logic [31:0] r3);
    fire_item_t it;
    it.opcode      = op;
    it.cell_index  = cell_no[IDX_W-1:0];
    it.rand_first  = r1;
    it.rand_second = r2;
    it.rand_third  = r3;
    pending_items.push_back(it);
  endtask

  // Mostly in-range cools mixed with frames, a few stray indexes.
  task automatic queue_random_items(input int count);
    int cell_no;
    logic [31:0] roll;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 65) begin
        cell_no = ($urandom_range(99) < 8) ? $urandom_range(63, 32) : $urandom_range(31, 0);
        queue_item(OP_COOL, cell_no, $urandom, $urandom, $urandom);
      end else begin
        roll = ($urandom_range(1) == 1) ? $urandom : $urandom_range(254, 0);
        queue_item(OP_FRAME, $urandom_range(63), roll, $urandom, $urandom);
      end
    end
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_register(input logic [REG_W-1:0] index, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (index)
      REG_COOLING_RATE:    cooling_rate_shadow    = value[COOL_W-1:0];
      REG_SPARK_THRESHOLD: spark_threshold_shadow = value[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Wait until every item is taken and every pixel is back, then let
  // any trailing cool item finish.
  task automatic drain_engine();
    while (pending_items.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct,
                           input int hold, input int count);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    hold_left      = hold;
    queue_random_items(count);
    drain_engine();
  endtask

  initial begin
    foreach (heat_shadow[i]) heat_shadow[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under reset register values (cooling 55, threshold 120).
    // Cold frame with no spark: all pixels black.
    queue_item(OP_FRAME, 0, 32'd254, 32'd0, 32'd0);
    // Largest spark into cell 0, then a second one that wraps past 255.
    queue_item(OP_FRAME, 0, 32'd0, 32'd7, 32'd94);
    queue_item(OP_FRAME, 0, 32'd0, 32'd14, 32'hFFFF_FFFF);
    // Spark into cell 1; roll of all ones is 0 mod 255, so it sparks.
    queue_item(OP_FRAME, 63, 32'hFFFF_FFFF, 32'd1, 32'd94);
    // Spark cell from an all-ones word, minimum added heat.
    queue_item(OP_FRAME, 0, 32'd119, 32'hFFFF_FFFF, 32'd0);
    // Roll exactly at the threshold: no spark.
    queue_item(OP_FRAME, 0, 32'd120, 32'd5, 32'd50);
    queue_item(OP_FRAME, 0, 32'd0, 32'd6, 32'd94);
    queue_item(OP_FRAME, 0, 32'd0, 32'd2, 32'd80);
    // Cools at the edges of the index range, out-of-range ones ignored.
    queue_item(OP_COOL, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_item(OP_COOL, PIXELS - 1, 32'd0, 32'd0, 32'd0);
    queue_item(OP_COOL, PIXELS, 32'd18, 32'd0, 32'd0);
    queue_item(OP_COOL, 63, 32'd18, 32'd0, 32'd0);
    // Largest cooldown on a cold cell floors at zero.
    queue_item(OP_COOL, 20, 32'd18, 32'd0, 32'd0);
    queue_item(OP_COOL, 1, 32'd17, 32'd0, 32'd0);
    queue_item(OP_FRAME, 0, 32'd254, 32'd0, 32'd0);
    queue_item(OP_FRAME, 0, 32'd3, 32'd3, 32'd60);
    queue_item(OP_FRAME, 0, 32'd4, 32'd4, 32'd70);
    queue_item(OP_FRAME, 0, 32'd5, 32'd0, 32'd90);
    queue_item(OP_FRAME, 0, 32'd254, 32'd0, 32'd0);
    queue_item(OP_FRAME, 0, 32'd254, 32'd0, 32'd0);
    drain_engine();

    // Widest cooling (upper bits dropped by the register), spark every frame.
    write_register(REG_COOLING_RATE, 32'hFFFF_FFFF);
    write_register(REG_SPARK_THRESHOLD, 32'd255);
    settings_run++;
    run_phase(51, 0, 0, 55);

    // Weakest cooling, never spark; long receiver hold-off fills the engine.
    write_register(REG_COOLING_RATE, 32'd0);
    write_register(REG_SPARK_THRESHOLD, 32'd0);
    settings_run++;
    run_phase(0, 51, PRESSURE_HOLD, 50);

    write_register(REG_COOLING_RATE, $urandom_range(1023));
    write_register(REG_SPARK_THRESHOLD, $urandom_range(255));
    settings_run++;
    run_phase(7, 7, 0, 55);

    write_register(REG_COOLING_RATE, 32'd55);
    write_register(REG_SPARK_THRESHOLD, 32'd200);
    settings_run++;
    run_phase(0, 0, 0, 50);

    $display("Run covered %0d items over %0d register settings: %0d frames, %0d sparks,",
             items_accepted, settings_run, frames_seen, sparks_seen);
    $display("%0d ignored cools, %0d pixels checked, %0d errors.",
             cools_ignored, pixels_checked, error_count);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
